### hdl/nmea_rmc_pkg.sv
// Shared constants, types and character helpers for the NMEA RMC sentence parser.
// Depends on nothing; imported by nmea_rmc_sentence_parser.
package nmea_rmc_pkg;

    localparam int MAX_LINE_DEF      = 512;
    localparam int MINUTE_DIGITS_DEF = 6;

    localparam int CHAR_W   = 8;
    localparam int DIGIT_W  = 4;
    localparam int PAIR_W   = 7;
    localparam int LAT_W    = 27;
    localparam int LON_W    = 31;
    localparam int LAT_ACC_W = 27;
    localparam int LON_ACC_W = 30;
    localparam int LAT_DEG_W = 7;
    localparam int LON_DEG_W = 10;
    localparam int FIELD_W  = 4;
    localparam int POS_W    = 4;
    localparam int PAIRS    = 6;
    localparam int PAIR_IDX_W = 3;

    localparam logic [19:0] DEG_UNIT = 20'd600000;

    localparam logic [CHAR_W-1:0] CHAR_CR     = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_LF     = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_DOLLAR = 8'h24;
    localparam logic [CHAR_W-1:0] CHAR_STAR   = 8'h2A;
    localparam logic [CHAR_W-1:0] CHAR_COMMA  = 8'h2C;
    localparam logic [CHAR_W-1:0] CHAR_DOT    = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_A      = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_C      = 8'h43;
    localparam logic [CHAR_W-1:0] CHAR_M      = 8'h4D;
    localparam logic [CHAR_W-1:0] CHAR_R      = 8'h52;
    localparam logic [CHAR_W-1:0] CHAR_S      = 8'h53;
    localparam logic [CHAR_W-1:0] CHAR_W_UP   = 8'h57;

    localparam logic [FIELD_W-1:0] FIELD_TYPE   = 4'd0;
    localparam logic [FIELD_W-1:0] FIELD_TIME   = 4'd1;
    localparam logic [FIELD_W-1:0] FIELD_STATUS = 4'd2;
    localparam logic [FIELD_W-1:0] FIELD_LAT    = 4'd3;
    localparam logic [FIELD_W-1:0] FIELD_NS     = 4'd4;
    localparam logic [FIELD_W-1:0] FIELD_LON    = 4'd5;
    localparam logic [FIELD_W-1:0] FIELD_EW     = 4'd6;
    localparam logic [FIELD_W-1:0] FIELD_DATE   = 4'd9;
    localparam logic [FIELD_W-1:0] FIELD_LAST   = 4'd15;

    localparam logic [PAIR_IDX_W-1:0] DATE_BASE = 3'd3;

    typedef enum logic [1:0] {
        TM_NONE,
        TM_R,
        TM_RM,
        TM_RMC
    } type_match_t;

    function automatic logic [DIGIT_W-1:0] dec_val(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] t;
        t = c - 8'h30;
        return (c >= 8'h30 && c <= 8'h39) ? t[DIGIT_W-1:0] : '0;
    endfunction

    function automatic logic [DIGIT_W-1:0] hex_val(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] t;
        logic [DIGIT_W-1:0] r;
        r = '0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            t = c - 8'h30;
            r = t[DIGIT_W-1:0];
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            t = c - 8'h37;
            r = t[DIGIT_W-1:0];
        end
        return r;
    endfunction

endpackage

### hdl/nmea_rmc_sentence_parser.sv
// NMEA RMC sentence parser: one character per transaction, one result per newline.
// A newline is taken into the input register; its result is registered once the result register is free.
// Throughput: one character per cycle, but a newline waits while a stalled result is held; next state is combinational.
// Reset: rst_n clears all parse state and empties both the input and the result register.
// There is no clearing pass; the block can take characters as soon as reset is released.
// Depends on nmea_rmc_pkg.
module nmea_rmc_sentence_parser
    import nmea_rmc_pkg::*;
#(
    parameter int MAX_LINE      = MAX_LINE_DEF,
    parameter int MINUTE_DIGITS = MINUTE_DIGITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [CHAR_W-1:0]        in_char,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     checksum_ok,
    output logic                     is_rmc,
    output logic                     fix_valid,
    output logic [PAIR_W-1:0]        hour,
    output logic [PAIR_W-1:0]        minute,
    output logic [PAIR_W-1:0]        second,
    output logic [PAIR_W-1:0]        day,
    output logic [PAIR_W-1:0]        month,
    output logic [PAIR_W-1:0]        year,
    output logic signed [LAT_W-1:0]  latitude,
    output logic signed [LON_W-1:0]  longitude
);

    localparam int LEN_W  = $clog2(MAX_LINE + 2);
    localparam int MDIG_W = $clog2(MINUTE_DIGITS + 1);
    localparam logic [LEN_W-1:0]  LEN_MAX  = LEN_W'(MAX_LINE);
    localparam logic [LEN_W-1:0]  LEN_SAT  = LEN_W'(MAX_LINE + 1);
    localparam logic [MDIG_W-1:0] MDIG_MAX = MDIG_W'(MINUTE_DIGITS);

    logic                     in_valid_reg;
    logic [CHAR_W-1:0]        in_char_reg;
    logic                     advance;
    logic                     out_free;
    logic                     is_lf;

    logic [CHAR_W-1:0]        xor_reg, xor_next;
    logic                     star_reg, star_next;
    logic [CHAR_W-1:0]        hex_reg, hex_next;
    logic [1:0]               hex_cnt_reg, hex_cnt_next;
    logic [LEN_W-1:0]         len_reg, len_next;
    logic [FIELD_W-1:0]       field_reg, field_next;
    logic [POS_W-1:0]         pos_reg, pos_next;
    type_match_t              type_reg, type_next;
    logic [PAIR_W-1:0]        pair_reg [PAIRS];
    logic [PAIR_W-1:0]        pair_next [PAIRS];
    logic [LAT_DEG_W-1:0]     lat_deg_reg, lat_deg_next;
    logic [LAT_ACC_W-1:0]     lat_acc_reg, lat_acc_next;
    logic [MDIG_W-1:0]        lat_mdig_reg, lat_mdig_next;
    logic [LON_DEG_W-1:0]     lon_deg_reg, lon_deg_next;
    logic [LON_ACC_W-1:0]     lon_acc_reg, lon_acc_next;
    logic [MDIG_W-1:0]        lon_mdig_reg, lon_mdig_next;
    logic                     fix_reg, fix_next;
    logic                     south_reg, south_next;
    logic                     west_reg, west_next;

    logic [DIGIT_W-1:0]       digit;
    logic [PAIR_IDX_W-1:0]    pair_idx;
    logic                     res_ok;
    logic                     res_rmc;
    logic                     res_data;
    logic [LAT_W-1:0]         lat_sum;
    logic [LON_W-1:0]         lon_sum;
    logic [LAT_W-1:0]         lat_res;
    logic [LON_W-1:0]         lon_res;

    logic                     out_valid_reg;
    logic                     ok_reg;
    logic                     rmc_reg;
    logic                     fixo_reg;
    logic [PAIR_W-1:0]        res_pair_reg [PAIRS];
    logic [LAT_W-1:0]         lat_out_reg;
    logic [LON_W-1:0]         lon_out_reg;

    assign is_lf    = (in_char_reg == CHAR_LF);
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = in_valid_reg && (!is_lf || out_free);
    assign in_stall = in_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_valid && !in_stall)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_char_reg <= in_char;
        end
    end

    assign digit    = dec_val(in_char_reg);
    assign pair_idx = ((field_reg == FIELD_DATE) ? DATE_BASE : '0)
                      + {1'b0, pos_reg[2:1]};

    assign res_ok   = star_reg && (xor_reg == hex_reg) && (len_reg <= LEN_MAX);
    assign res_rmc  = (type_reg == TM_RMC);
    assign res_data = res_ok && res_rmc;
    assign lat_sum  = LAT_W'(lat_deg_reg) * LAT_W'(DEG_UNIT) + LAT_W'(lat_acc_reg);
    assign lon_sum  = LON_W'(lon_deg_reg) * LON_W'(DEG_UNIT) + LON_W'(lon_acc_reg);
    assign lat_res  = south_reg ? (LAT_W'(0) - lat_sum) : lat_sum;
    assign lon_res  = west_reg ? (LON_W'(0) - lon_sum) : lon_sum;

    always_comb
    begin
        xor_next      = xor_reg;
        star_next     = star_reg;
        hex_next      = hex_reg;
        hex_cnt_next  = hex_cnt_reg;
        len_next      = len_reg;
        field_next    = field_reg;
        pos_next      = pos_reg;
        type_next     = type_reg;
        pair_next     = pair_reg;
        lat_deg_next  = lat_deg_reg;
        lat_acc_next  = lat_acc_reg;
        lat_mdig_next = lat_mdig_reg;
        lon_deg_next  = lon_deg_reg;
        lon_acc_next  = lon_acc_reg;
        lon_mdig_next = lon_mdig_reg;
        fix_next      = fix_reg;
        south_next    = south_reg;
        west_next     = west_reg;

        if (in_char_reg == CHAR_CR)
        begin
            // Carriage return leaves the line state untouched.
        end
        else if (is_lf)
        begin
            xor_next      = '0;
            star_next     = 1'b0;
            hex_next      = '0;
            hex_cnt_next  = '0;
            len_next      = '0;
            field_next    = '0;
            pos_next      = '0;
            type_next     = TM_NONE;
            for (int i = 0; i < PAIRS; i++)
            begin
                pair_next[i] = '0;
            end
            lat_deg_next  = '0;
            lat_acc_next  = '0;
            lat_mdig_next = '0;
            lon_deg_next  = '0;
            lon_acc_next  = '0;
            lon_mdig_next = '0;
            fix_next      = 1'b0;
            south_next    = 1'b0;
            west_next     = 1'b0;
        end
        else
        begin
            if (len_reg != LEN_SAT)
            begin
                len_next = len_reg + 1'b1;
            end
            if ((len_reg == '0) && (in_char_reg == CHAR_DOLLAR))
            begin
                // A leading dollar sign is not part of the sentence.
            end
            else if (star_reg)
            begin
                if (hex_cnt_reg == 2'd0)
                begin
                    hex_next     = {hex_val(in_char_reg), 4'h0};
                    hex_cnt_next = 2'd1;
                end
                else if (hex_cnt_reg == 2'd1)
                begin
                    hex_next     = {hex_reg[7:4], hex_val(in_char_reg)};
                    hex_cnt_next = 2'd2;
                end
            end
            else if (in_char_reg == CHAR_STAR)
            begin
                star_next = 1'b1;
            end
            else
            begin
                xor_next = xor_reg ^ in_char_reg;
                if (in_char_reg == CHAR_COMMA)
                begin
                    if (field_reg != FIELD_LAST)
                    begin
                        field_next = field_reg + 1'b1;
                    end
                    pos_next = '0;
                end
                else
                begin
                    case (field_reg) inside
                        FIELD_TYPE:
                        begin
                            if (pos_reg == 4'd2)
                            begin
                                type_next = (in_char_reg == CHAR_R) ? TM_R : TM_NONE;
                            end
                            else if (pos_reg == 4'd3)
                            begin
                                type_next = (type_reg == TM_R && in_char_reg == CHAR_M)
                                            ? TM_RM : TM_NONE;
                            end
                            else if (pos_reg == 4'd4)
                            begin
                                type_next = (type_reg == TM_RM && in_char_reg == CHAR_C)
                                            ? TM_RMC : TM_NONE;
                            end
                        end
                        FIELD_TIME, FIELD_DATE:
                        begin
                            if (pos_reg < 4'd6)
                            begin
                                if (!pos_reg[0])
                                begin
                                    pair_next[pair_idx] = PAIR_W'(digit) * PAIR_W'(10);
                                end
                                else
                                begin
                                    pair_next[pair_idx] = pair_reg[pair_idx] + PAIR_W'(digit);
                                end
                            end
                        end
                        FIELD_STATUS:
                        begin
                            if (pos_reg == '0 && in_char_reg == CHAR_A)
                            begin
                                fix_next = 1'b1;
                            end
                        end
                        FIELD_LAT:
                        begin
                            if (pos_reg == 4'd0)
                            begin
                                lat_deg_next = LAT_DEG_W'(digit) * LAT_DEG_W'(10);
                            end
                            else if (pos_reg == 4'd1)
                            begin
                                lat_deg_next = lat_deg_reg + LAT_DEG_W'(digit);
                            end
                            else if (in_char_reg != CHAR_DOT && lat_mdig_reg < MDIG_MAX)
                            begin
                                lat_acc_next  = lat_acc_reg * LAT_ACC_W'(10)
                                                + LAT_ACC_W'(digit);
                                lat_mdig_next = lat_mdig_reg + 1'b1;
                            end
                        end
                        FIELD_NS:
                        begin
                            if (pos_reg == '0 && in_char_reg == CHAR_S)
                            begin
                                south_next = 1'b1;
                            end
                        end
                        FIELD_LON:
                        begin
                            if (pos_reg == 4'd0)
                            begin
                                lon_deg_next = LON_DEG_W'(digit) * LON_DEG_W'(100);
                            end
                            else if (pos_reg == 4'd1)
                            begin
                                lon_deg_next = lon_deg_reg
                                               + LON_DEG_W'(digit) * LON_DEG_W'(10);
                            end
                            else if (pos_reg == 4'd2)
                            begin
                                lon_deg_next = lon_deg_reg + LON_DEG_W'(digit);
                            end
                            else if (in_char_reg != CHAR_DOT && lon_mdig_reg < MDIG_MAX)
                            begin
                                lon_acc_next  = lon_acc_reg * LON_ACC_W'(10)
                                                + LON_ACC_W'(digit);
                                lon_mdig_next = lon_mdig_reg + 1'b1;
                            end
                        end
                        FIELD_EW:
                        begin
                            if (pos_reg == '0 && in_char_reg == CHAR_W_UP)
                            begin
                                west_next = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    if (pos_reg != 4'd15)
                    begin
                        pos_next = pos_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xor_reg      <= '0;
            star_reg     <= 1'b0;
            hex_reg      <= '0;
            hex_cnt_reg  <= '0;
            len_reg      <= '0;
            field_reg    <= '0;
            pos_reg      <= '0;
            type_reg     <= TM_NONE;
            for (int i = 0; i < PAIRS; i++)
            begin
                pair_reg[i] <= '0;
            end
            lat_deg_reg  <= '0;
            lat_acc_reg  <= '0;
            lat_mdig_reg <= '0;
            lon_deg_reg  <= '0;
            lon_acc_reg  <= '0;
            lon_mdig_reg <= '0;
            fix_reg      <= 1'b0;
            south_reg    <= 1'b0;
            west_reg     <= 1'b0;
        end
        else if (advance)
        begin
            xor_reg      <= xor_next;
            star_reg     <= star_next;
            hex_reg      <= hex_next;
            hex_cnt_reg  <= hex_cnt_next;
            len_reg      <= len_next;
            field_reg    <= field_next;
            pos_reg      <= pos_next;
            type_reg     <= type_next;
            pair_reg     <= pair_next;
            lat_deg_reg  <= lat_deg_next;
            lat_acc_reg  <= lat_acc_next;
            lat_mdig_reg <= lat_mdig_next;
            lon_deg_reg  <= lon_deg_next;
            lon_acc_reg  <= lon_acc_next;
            lon_mdig_reg <= lon_mdig_next;
            fix_reg      <= fix_next;
            south_reg    <= south_next;
            west_reg     <= west_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && is_lf)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && is_lf)
        begin
            ok_reg   <= res_ok;
            rmc_reg  <= res_rmc;
            fixo_reg <= res_data && fix_reg;
            for (int i = 0; i < PAIRS; i++)
            begin
                res_pair_reg[i] <= res_data ? pair_reg[i] : '0;
            end
            lat_out_reg <= res_data ? lat_res : '0;
            lon_out_reg <= res_data ? lon_res : '0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign checksum_ok = ok_reg;
    assign is_rmc      = rmc_reg;
    assign fix_valid   = fixo_reg;
    assign hour        = res_pair_reg[0];
    assign minute      = res_pair_reg[1];
    assign second      = res_pair_reg[2];
    assign day         = res_pair_reg[3];
    assign month       = res_pair_reg[4];
    assign year        = res_pair_reg[5];
    assign latitude    = $signed(lat_out_reg);
    assign longitude   = $signed(lon_out_reg);

endmodule
